### sv/cbnp_pkg.sv
// Shared types and constants for the custom base number parser.
package cbnp_pkg;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned COUNT_W   = 5;
	localparam int unsigned SYM_IDX_W = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 64;

	localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CH_W-1:0] CH_BANG  = 8'd33;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
	localparam logic [CH_W-1:0] CH_SLASH = 8'd47;
	localparam logic [CH_W-1:0] CH_COLON = 8'd58;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYMBOL_COUNT = 2'd0,
		REG_SYMBOLS_LOW  = 2'd1,
		REG_SYMBOLS_HIGH = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_NUMBER = 2'd1,
		ST_BAD_ALPH  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_PREFIX = 2'd0,
		PH_RUN    = 2'd1,
		PH_DONE   = 2'd2,
		PH_REJECT = 2'd3
	} phase_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            last;
	} in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [1:0]                status;
	} out_t;

	// Alphabet check and symbol lookup for the character in flight
	typedef struct packed {
		logic                 ok;
		logic [COUNT_W-1:0]   radix;
		logic                 hit;
		logic [SYM_IDX_W-1:0] idx;
	} alph_t;

endpackage

### sv/cbnp_alphabet.sv
// Alphabet registers, validity check and symbol lookup.
module cbnp_alphabet #(
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cbnp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cbnp_pkg::CFG_W-1:0]          cfg_data,
	input  logic [cbnp_pkg::CH_W-1:0]           look_ch,
	output cbnp_pkg::alph_t                     alph
);

	logic [cbnp_pkg::COUNT_W-1:0] count_q;
	logic [cbnp_pkg::CH_W-1:0]    sym_q [MAX_SYMBOLS];
	logic                         ok_q;

	logic [MAX_SYMBOLS-1:0] used;
	logic [MAX_SYMBOLS-1:0] bad_sym;
	logic [MAX_SYMBOLS-1:0] hit_vec;
	logic                   dup;
	logic                   count_ok;
	logic                   ok_d;
	logic [cbnp_pkg::SYM_IDX_W-1:0] idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int k = 0; k < MAX_SYMBOLS; k++) begin
				sym_q[k] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == cbnp_pkg::REG_SYMBOL_COUNT) begin
				count_q <= cfg_data[cbnp_pkg::COUNT_W-1:0];
			end
			for (int k = 0; k < MAX_SYMBOLS; k++) begin
				if ((cfg_index == cbnp_pkg::REG_SYMBOLS_LOW && k < 8) ||
				    (cfg_index == cbnp_pkg::REG_SYMBOLS_HIGH && k >= 8)) begin
					sym_q[k] <= cfg_data[8*(k%8) +: 8];
				end
			end
		end
	end

	always_comb begin
		count_ok = (count_q >= cbnp_pkg::COUNT_W'(2)) &&
		           (count_q <= cbnp_pkg::COUNT_W'(MAX_SYMBOLS));
		dup = 1'b0;
		for (int k = 0; k < MAX_SYMBOLS; k++) begin
			used[k]    = cbnp_pkg::COUNT_W'(k) < count_q;
			bad_sym[k] = used[k] && (sym_q[k] == cbnp_pkg::CH_PLUS ||
			             sym_q[k] == cbnp_pkg::CH_MINUS || sym_q[k] < cbnp_pkg::CH_BANG);
		end
		// used[j] implies used[i] for i < j
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
				if (used[j] && sym_q[i] == sym_q[j]) begin
					dup = 1'b1;
				end
			end
		end
		ok_d = count_ok && !(|bad_sym) && !dup;
	end

	// User must change config only while idle (not enforced); verdict is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else begin
			ok_q <= ok_d;
		end
	end

	// Symbols are distinct whenever the result is used, so OR the matching indexes
	always_comb begin
		idx = '0;
		for (int k = 0; k < MAX_SYMBOLS; k++) begin
			hit_vec[k] = used[k] && (sym_q[k] == look_ch);
			if (hit_vec[k]) begin
				idx = idx | cbnp_pkg::SYM_IDX_W'(k);
			end
		end
	end

	assign alph.ok    = ok_q;
	assign alph.radix = count_q;
	assign alph.hit   = |hit_vec;
	assign alph.idx   = idx;

endmodule

### sv/cbnp_core.sv
// Input register, parse state update and result register.
module cbnp_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  cbnp_pkg::in_t             in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output cbnp_pkg::out_t            out_data,
	output logic [cbnp_pkg::CH_W-1:0] look_ch,
	input  cbnp_pkg::alph_t           alph
);

	logic                                valid_s1;
	cbnp_pkg::in_t                       in_s1;
	cbnp_pkg::phase_t                    phase_q, phase_d;
	logic                                neg_q, neg_d;
	logic [cbnp_pkg::VALUE_W-1:0]        acc_q, acc_d;
	logic                                out_valid_q;
	cbnp_pkg::out_t                      out_q;
	cbnp_pkg::out_t                      res;
	logic                                fire;
	logic                                skip_ch;

	// A last character needs room in the result register; others never wait
	assign fire     = valid_s1 && (!in_s1.last || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;
	assign look_ch  = in_s1.ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	assign skip_ch = (in_s1.ch <= cbnp_pkg::CH_SPACE) || (in_s1.ch == cbnp_pkg::CH_PLUS) ||
	                 (in_s1.ch > cbnp_pkg::CH_SLASH && in_s1.ch < cbnp_pkg::CH_COLON);

	// Next state
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		if (alph.ok) begin
			unique case (phase_q)
				cbnp_pkg::PH_PREFIX: begin
					if (alph.hit) begin
						acc_d   = {{(cbnp_pkg::VALUE_W-cbnp_pkg::SYM_IDX_W){1'b0}}, alph.idx};
						phase_d = cbnp_pkg::PH_RUN;
					end else if (in_s1.ch == cbnp_pkg::CH_MINUS) begin
						neg_d = ~neg_q;
					end else if (!skip_ch) begin
						phase_d = cbnp_pkg::PH_REJECT;
					end
				end
				cbnp_pkg::PH_RUN: begin
					if (alph.hit) begin
						acc_d = acc_q * {{(cbnp_pkg::VALUE_W-cbnp_pkg::COUNT_W){1'b0}}, alph.radix}
						      + {{(cbnp_pkg::VALUE_W-cbnp_pkg::SYM_IDX_W){1'b0}}, alph.idx};
					end else begin
						phase_d = cbnp_pkg::PH_DONE;
					end
				end
				// hold once the run has ended or the string is rejected
				default: begin
				end
			endcase
		end
	end

	// Result for a last character
	always_comb begin
		res.value  = '0;
		res.status = cbnp_pkg::ST_NO_NUMBER;
		if (!alph.ok) begin
			res.status = cbnp_pkg::ST_BAD_ALPH;
		end else if (phase_d == cbnp_pkg::PH_RUN || phase_d == cbnp_pkg::PH_DONE) begin
			res.value  = neg_d ? $signed(~acc_d + 32'd1) : $signed(acc_d);
			res.status = cbnp_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cbnp_pkg::PH_PREFIX;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (fire) begin
			if (in_s1.last) begin
				phase_q <= cbnp_pkg::PH_PREFIX;
				neg_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				acc_q   <= acc_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && in_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && in_s1.last) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_s1.last |=> phase_q == cbnp_pkg::PH_PREFIX && !neg_q && acc_q == '0)
		else $error("parse state not cleared after last character");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_s1.last |=> out_valid_q)
		else $error("last character produced no result");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != cbnp_pkg::ST_OK |-> out_q.value == '0)
		else $error("nonzero value with failure status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.status == cbnp_pkg::ST_OK ||
		out_q.status == cbnp_pkg::ST_NO_NUMBER || out_q.status == cbnp_pkg::ST_BAD_ALPH)
		else $error("undefined status code");

	a_bad_alph_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !in_s1.last && !alph.ok |=> $stable(phase_q) && $stable(acc_q))
		else $error("state moved under invalid alphabet");
`endif

endmodule

### sv/custom_base_number_parser.sv
// Top level: string-to-integer parser over a configured symbol alphabet.
// Input channel in_valid/in_ready/in_data carries one character per transaction,
// with in_data.last marking the final character of a string. Output channel
// out_valid/out_ready/out_data carries one result per string: the signed value
// and a status (parsed, no number, invalid alphabet).
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the symbol
// count and the two symbol words; cfg_ready is always high. Write only while idle.
// Throughput: one character per cycle while the result register can take a final
// character. Each character is registered, then the alphabet lookup and the
// accumulator multiply-add finish in the following cycle, the single loop
// that sets the rate. The last character waits in the input register until the
// result register is free; the result is then registered and out_valid rises.
// The alphabet verdict is registered from the symbol count and symbol registers.
// When out_ready is low, the result is held; non-final characters keep flowing,
// and a final character waits in the input register until the result slot frees.
// Reset clears the alphabet (invalid), the parse state and both valid flags.
module custom_base_number_parser #(
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  cbnp_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output cbnp_pkg::out_t                 out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cbnp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbnp_pkg::CFG_W-1:0]     cfg_data
);

	cbnp_pkg::alph_t           alph;
	logic [cbnp_pkg::CH_W-1:0] look_ch;

	assign cfg_ready = 1'b1;

	cbnp_alphabet #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_alphabet (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.look_ch  (look_ch),
		.alph     (alph)
	);

	cbnp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.look_ch  (look_ch),
		.alph     (alph)
	);

endmodule
